// ===== sv/phf_pkg.sv =====
// Shared types, widths and the flux saturation helper for the pressureless
// HLLE flux block. No dependencies.
`default_nettype none
package phf_pkg;

   localparam int FIELD_W = 32;
   localparam int FLUX_W  = 48;
   localparam int SAT_W   = 128;

   localparam logic [SAT_W-1:0] POS_LIM = (SAT_W'(1) << (FLUX_W - 1)) - SAT_W'(1);
   localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(1) << (FLUX_W - 1);
   localparam logic [FLUX_W-1:0] FLUX_MAX = POS_LIM[FLUX_W-1:0];
   localparam logic [FLUX_W-1:0] FLUX_MIN = NEG_LIM[FLUX_W-1:0];

   typedef struct packed {
      logic        [FIELD_W-1:0] rho_left;
      logic signed [FIELD_W-1:0] vn_left;
      logic signed [FIELD_W-1:0] vt1_left;
      logic signed [FIELD_W-1:0] vt2_left;
      logic        [FIELD_W-1:0] rho_right;
      logic signed [FIELD_W-1:0] vn_right;
      logic signed [FIELD_W-1:0] vt1_right;
      logic signed [FIELD_W-1:0] vt2_right;
   } req_type;

   typedef struct packed {
      logic    neg;
      req_type req;
   } div1_side_type;

   typedef struct packed {
      req_type                  req;
      logic [2*FIELD_W-1:0]     fl_full;
      logic [2*FIELD_W-1:0]     fr_full;
      logic                     span_zero;
   } div2_side_type;

   typedef struct packed {
      logic              sat;
      logic [FLUX_W-1:0] value;
   } sat_type;

   // clip a sign-magnitude value to the 48-bit two's complement range
   function automatic sat_type sat_flux(input logic neg, input logic [SAT_W-1:0] mag);
      sat_type          r;
      logic [SAT_W-1:0] lim;
      lim = neg ? NEG_LIM : POS_LIM;
      if (mag > lim) begin
         r.sat   = 1'b1;
         r.value = lim[FLUX_W-1:0];
      end else begin
         r.sat   = 1'b0;
         r.value = mag[FLUX_W-1:0];
      end
      if (neg) begin
         r.value = -r.value;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/phf_channels.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on phf_pkg.
`default_nettype none
interface phf_req_if;
   import phf_pkg::*;
   logic                      valid;
   logic                      ready;
   logic        [FIELD_W-1:0] rho_left;
   logic signed [FIELD_W-1:0] vn_left;
   logic signed [FIELD_W-1:0] vt1_left;
   logic signed [FIELD_W-1:0] vt2_left;
   logic        [FIELD_W-1:0] rho_right;
   logic signed [FIELD_W-1:0] vn_right;
   logic signed [FIELD_W-1:0] vt1_right;
   logic signed [FIELD_W-1:0] vt2_right;
   modport source (output valid, rho_left, vn_left, vt1_left, vt2_left,
                   rho_right, vn_right, vt1_right, vt2_right, input ready);
   modport sink   (input valid, rho_left, vn_left, vt1_left, vt2_left,
                   rho_right, vn_right, vt1_right, vt2_right, output ready);
endinterface

interface phf_rsp_if;
   import phf_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [FLUX_W-1:0] mass_flux;
   logic signed [FLUX_W-1:0] normal_mom_flux;
   logic signed [FLUX_W-1:0] trans1_mom_flux;
   logic signed [FLUX_W-1:0] trans2_mom_flux;
   logic                     saturated;
   logic                     vacuum;
   modport source (output valid, mass_flux, normal_mom_flux, trans1_mom_flux,
                   trans2_mom_flux, saturated, vacuum, input ready);
   modport sink   (input valid, mass_flux, normal_mom_flux, trans1_mom_flux,
                   trans2_mom_flux, saturated, vacuum, output ready);
endinterface
`default_nettype wire

// ===== sv/phf_sqrt_pipe.sv =====
// Pipelined digit-by-digit integer square root, two lanes, one result bit
// per stage, with a sideband that travels alongside. No dependencies.
`default_nettype none
module phf_sqrt_pipe #(
   parameter int XW = 48,
   parameter int SW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic [XW-1:0]         x0,
   input  logic [XW-1:0]         x1,
   input  logic [SW-1:0]         in_side,
   output logic                  out_valid,
   output logic [(XW+1)/2-1:0]   r0,
   output logic [(XW+1)/2-1:0]   r1,
   output logic [SW-1:0]         out_side
);
   localparam int RW   = (XW + 1) / 2;
   localparam int PW   = 2 * RW;
   localparam int REMW = RW + 3;

   logic [REMW-1:0] rem_ff  [RW][2];
   logic [RW-1:0]   root_ff [RW][2];
   logic [PW-1:0]   rad_ff  [RW][2];
   logic [RW-1:0]   valid_ff;
   logic [SW-1:0]   side_ff [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [REMW-1:0] rem_src  [2];
      logic [RW-1:0]   root_src [2];
      logic [PW-1:0]   rad_src  [2];
      logic            valid_src;
      logic [SW-1:0]   side_src;
      logic [REMW-1:0] shifted  [2];
      logic [REMW-1:0] trial    [2];
      logic [1:0]      ge;
      logic [REMW-1:0] rem_in   [2];
      logic [RW-1:0]   root_in  [2];
      logic [PW-1:0]   rad_in   [2];

      if (i == 0) begin : g_head
         always_comb begin
            rem_src[0]  = '0;
            rem_src[1]  = '0;
            root_src[0] = '0;
            root_src[1] = '0;
            rad_src[0]  = PW'(x0);
            rad_src[1]  = PW'(x1);
            valid_src   = in_valid;
            side_src    = in_side;
         end
      end else begin : g_body
         always_comb begin
            for (int k = 0; k < 2; k++) begin
               rem_src[k]  = rem_ff[i-1][k];
               root_src[k] = root_ff[i-1][k];
               rad_src[k]  = rad_ff[i-1][k];
            end
            valid_src = valid_ff[i-1];
            side_src  = side_ff[i-1];
         end
      end

      always_comb begin
         for (int k = 0; k < 2; k++) begin
            shifted[k] = {rem_src[k][REMW-3:0], rad_src[k][PW-1:PW-2]};
            trial[k]   = {1'b0, root_src[k], 2'b01};
            ge[k]      = shifted[k] >= trial[k];
            rem_in[k]  = ge[k] ? shifted[k] - trial[k] : shifted[k];
            root_in[k] = {root_src[k][RW-2:0], ge[k]};
            rad_in[k]  = rad_src[k] << 2;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            for (int k = 0; k < 2; k++) begin
               rem_ff[i][k]  <= rem_in[k];
               root_ff[i][k] <= root_in[k];
               rad_ff[i][k]  <= rad_in[k];
            end
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign r0        = root_ff[RW-1][0];
   assign r1        = root_ff[RW-1][1];
   assign out_side  = side_ff[RW-1];

endmodule
`default_nettype wire

// ===== sv/phf_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// The quotient must fit in QB bits. No dependencies.
`default_nettype none
module phf_div_pipe #(
   parameter int DW = 64,
   parameter int VW = 32,
   parameter int QB = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QB-1:0] quotient,
   output logic [SW-1:0] out_side
);
   logic [VW-1:0] rem_ff  [QB];
   logic [QB-1:0] bits_ff [QB];
   logic [VW-1:0] div_ff  [QB];
   logic [QB-1:0] valid_ff;
   logic [SW-1:0] side_ff [QB];

   for (genvar i = 0; i < QB; i++) begin : g_stage
      logic [VW-1:0] rem_src;
      logic [QB-1:0] bits_src;
      logic [VW-1:0] div_src;
      logic          valid_src;
      logic [SW-1:0] side_src;
      logic [VW:0]   trial;
      logic          ge;
      logic [VW-1:0] rem_in;
      logic [QB-1:0] bits_in;

      if (i == 0) begin : g_head
         always_comb begin
            rem_src   = VW'(dividend >> QB);
            bits_src  = dividend[QB-1:0];
            div_src   = divisor;
            valid_src = in_valid;
            side_src  = in_side;
         end
      end else begin : g_body
         always_comb begin
            rem_src   = rem_ff[i-1];
            bits_src  = bits_ff[i-1];
            div_src   = div_ff[i-1];
            valid_src = valid_ff[i-1];
            side_src  = side_ff[i-1];
         end
      end

      // dividend bits shift out the top, quotient bits shift in the bottom
      always_comb begin
         trial   = {rem_src, bits_src[QB-1]};
         ge      = trial >= {1'b0, div_src};
         rem_in  = ge ? VW'(trial - {1'b0, div_src}) : trial[VW-1:0];
         bits_in = {bits_src[QB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= rem_in;
            bits_ff[i] <= bits_in;
            div_ff[i]  <= div_src;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign quotient  = bits_ff[QB-1];
   assign out_side  = side_ff[QB-1];

endmodule
`default_nettype wire

// ===== sv/pressureless_hlle_flux.sv =====
// Pressureless HLLE interface flux. Top level: square roots, weighted
// average, wave speeds, flux weights and saturating fluxes.
// Depends on phf_pkg, phf_channels, phf_sqrt_pipe, phf_div_pipe.
//
// Usage: one request beat carries one cell interface (left/right density,
// normal and two transverse velocities); one response beat returns the mass
// flux, three momentum fluxes, a saturated flag and a vacuum flag.
// Throughput: one beat per cycle, sustained while no response is stalled.
// Stages: the square root pipe (one root bit per stage), the
// average-velocity divider (32 stages), the flux-weight divider (33
// stages) and ten multiply/add/saturate stages.
// Reset clears every stage valid bit; the pipe comes out of reset empty and
// ready. When the receiver holds rsp ready low with a result waiting, the
// whole pipe holds in place and req ready drops; nothing is lost or repeated.
// req ready is high whenever the output register is empty or being taken.
`default_nettype none
module pressureless_hlle_flux #(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   phf_req_if.sink   req_chan,
   phf_rsp_if.source rsp_chan
);
   import phf_pkg::*;

   localparam int XW   = FIELD_W + FRAC_BITS;
   localparam int RW   = (XW + 1) / 2;
   localparam int PRW  = RW + FIELD_W + 1;
   localparam int DENW = RW + 1;
   localparam int WW   = FIELD_W + 1;
   localparam int FLW  = 2 * FIELD_W - FRAC_BITS;
   localparam int AW   = FLW + FIELD_W;
   localparam int REQW = $bits(req_type);
   localparam int D1W  = $bits(div1_side_type);
   localparam int D2W  = $bits(div2_side_type);
   localparam logic [WW-1:0] HALF_W = WW'(1) << (FIELD_W - 1);
   localparam logic [WW-1:0] ONE_W  = WW'(1) << FIELD_W;

   logic adv;
   logic out_valid_ff;

   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------- square roots ----------------
   req_type       req_in;
   logic          sq_valid;
   logic [RW-1:0] sq_l, sq_r;
   logic [REQW-1:0] sq_side;
   req_type       sq_req;

   always_comb begin
      req_in.rho_left  = req_chan.rho_left;
      req_in.vn_left   = req_chan.vn_left;
      req_in.vt1_left  = req_chan.vt1_left;
      req_in.vt2_left  = req_chan.vt2_left;
      req_in.rho_right = req_chan.rho_right;
      req_in.vn_right  = req_chan.vn_right;
      req_in.vt1_right = req_chan.vt1_right;
      req_in.vt2_right = req_chan.vt2_right;
   end

   phf_sqrt_pipe #(.XW(XW), .SW(REQW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (req_chan.valid && adv),
      .x0       (XW'(req_in.rho_left) << FRAC_BITS),
      .x1       (XW'(req_in.rho_right) << FRAC_BITS),
      .in_side  (req_in),
      .out_valid(sq_valid),
      .r0       (sq_l),
      .r1       (sq_r),
      .out_side (sq_side)
   );
   assign sq_req = req_type'(sq_side);

   // ---------------- weighted products ----------------
   logic                  m1_valid_ff;
   logic signed [PRW-1:0] m1_pl_ff, m1_pr_ff, m1_pl_in, m1_pr_in;
   logic [DENW-1:0]       m1_den_ff;
   req_type               m1_req_ff;
   logic signed [RW:0]    sq_l_s, sq_r_s;

   always_comb begin
      sq_l_s   = $signed({1'b0, sq_l});
      sq_r_s   = $signed({1'b0, sq_r});
      m1_pl_in = sq_l_s * sq_req.vn_left;
      m1_pr_in = sq_r_s * sq_req.vn_right;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_pl_ff  <= m1_pl_in;
         m1_pr_ff  <= m1_pr_in;
         m1_den_ff <= DENW'(sq_l) + DENW'(sq_r);
         m1_req_ff <= sq_req;
      end
   end

   // ---------------- numerator sum, sign-magnitude ----------------
   logic                m2_valid_ff;
   logic signed [PRW:0] m2_num;
   logic                m2_neg_ff;
   logic [PRW-1:0]      m2_mag_ff, m2_mag_in;
   logic [DENW-1:0]     m2_den_ff;
   req_type             m2_req_ff;

   always_comb begin
      m2_num    = (PRW+1)'(m1_pl_ff) + (PRW+1)'(m1_pr_ff);
      m2_mag_in = m2_num[PRW] ? PRW'(-m2_num) : m2_num[PRW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_neg_ff <= m2_num[PRW];
         m2_mag_ff <= m2_mag_in;
         m2_den_ff <= m1_den_ff;
         m2_req_ff <= m1_req_ff;
      end
   end

   // ---------------- average normal velocity ----------------
   div1_side_type        dv1_side_in, dv1_side;
   logic [D1W-1:0]       dv1_side_out;
   logic                 dv1_valid;
   logic [FIELD_W-1:0]   dv1_q;

   always_comb begin
      dv1_side_in.neg = m2_neg_ff;
      dv1_side_in.req = m2_req_ff;
   end

   phf_div_pipe #(.DW(PRW), .VW(DENW), .QB(FIELD_W), .SW(D1W)) u_div_avg (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (m2_valid_ff),
      .dividend (m2_mag_ff),
      .divisor  (m2_den_ff),
      .in_side  (dv1_side_in),
      .out_valid(dv1_valid),
      .quotient (dv1_q),
      .out_side (dv1_side_out)
   );
   assign dv1_side = div1_side_type'(dv1_side_out);

   // ---------------- wave speeds ----------------
   logic                      d1_valid_ff;
   logic signed [FIELD_W-1:0] avg_u, al, ar, bp, bm;
   logic signed [FIELD_W:0]   dl_w, dr_w, span_w;
   logic signed [FIELD_W-1:0] d1_bp_ff;
   logic [FIELD_W-1:0]        d1_span_ff, d1_dl_ff, d1_dr_ff;
   req_type                   d1_req_ff;

   always_comb begin
      avg_u  = dv1_side.neg ? -$signed(dv1_q) : $signed(dv1_q);
      al     = (avg_u < dv1_side.req.vn_left) ? avg_u : dv1_side.req.vn_left;
      ar     = (avg_u > dv1_side.req.vn_right) ? avg_u : dv1_side.req.vn_right;
      bp     = (ar > 0) ? ar : '0;
      bm     = (al < 0) ? al : '0;
      span_w = (FIELD_W+1)'(bp) - (FIELD_W+1)'(bm);
      dl_w   = (FIELD_W+1)'(dv1_side.req.vn_left) - (FIELD_W+1)'(bm);
      dr_w   = (FIELD_W+1)'(bp) - (FIELD_W+1)'(dv1_side.req.vn_right);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
      end else if (adv) begin
         d1_valid_ff <= dv1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_bp_ff   <= bp;
         d1_span_ff <= span_w[FIELD_W-1:0];
         d1_dl_ff   <= dl_w[FIELD_W-1:0];
         d1_dr_ff   <= dr_w[FIELD_W-1:0];
         d1_req_ff  <= dv1_side.req;
      end
   end

   // ---------------- one-sided mass fluxes ----------------
   logic                   e1_valid_ff;
   logic [2*FIELD_W-1:0]   e1_fl_in, e1_fr_in;
   logic signed [FIELD_W-1:0] e1_bp_ff;
   logic [FIELD_W-1:0]     e1_span_ff;
   div2_side_type          e1_side_ff;

   always_comb begin
      e1_fl_in = d1_dl_ff * d1_req_ff.rho_left;
      e1_fr_in = d1_dr_ff * d1_req_ff.rho_right;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (adv) begin
         e1_valid_ff <= d1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_bp_ff             <= d1_bp_ff;
         e1_span_ff           <= d1_span_ff;
         e1_side_ff.req       <= d1_req_ff;
         e1_side_ff.fl_full   <= e1_fl_in;
         e1_side_ff.fr_full   <= e1_fr_in;
         e1_side_ff.span_zero <= (d1_span_ff == '0);
      end
   end

   // ---------------- left weight bp / (bp - bm) in Q1.32 ----------------
   logic               dv2_valid;
   logic [WW-1:0]      dv2_q;
   logic [D2W-1:0]     dv2_side_out;
   div2_side_type      dv2_side;

   phf_div_pipe #(.DW(2*FIELD_W-1), .VW(FIELD_W), .QB(WW), .SW(D2W)) u_div_wt (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (e1_valid_ff),
      .dividend ({e1_bp_ff[FIELD_W-2:0], {FIELD_W{1'b0}}}),
      .divisor  (e1_span_ff),
      .in_side  (e1_side_ff),
      .out_valid(dv2_valid),
      .quotient (dv2_q),
      .out_side (dv2_side_out)
   );
   assign dv2_side = div2_side_type'(dv2_side_out);

   // ---------------- weighted fluxes, partial products ----------------
   logic                  g1_valid_ff;
   logic [WW-1:0]         wl, wr;
   logic [FLW-1:0]        fl, fr;
   logic [FIELD_W+WW-1:0] g1_ll_in, g1_rl_in, g1_ll_ff, g1_rl_ff;
   logic [FLW:0]          g1_lh_in, g1_rh_in, g1_lh_ff, g1_rh_ff;
   req_type               g1_req_ff;

   always_comb begin
      wl       = dv2_side.span_zero ? HALF_W : dv2_q;
      wr       = ONE_W - wl;
      fl       = dv2_side.fl_full[2*FIELD_W-1:FRAC_BITS];
      fr       = dv2_side.fr_full[2*FIELD_W-1:FRAC_BITS];
      g1_ll_in = fl[FIELD_W-1:0] * wl;
      g1_lh_in = fl[FLW-1:FIELD_W] * wl;
      g1_rl_in = fr[FIELD_W-1:0] * wr;
      g1_rh_in = fr[FLW-1:FIELD_W] * wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_valid_ff <= 1'b0;
      end else if (adv) begin
         g1_valid_ff <= dv2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g1_ll_ff  <= g1_ll_in;
         g1_lh_ff  <= g1_lh_in;
         g1_rl_ff  <= g1_rl_in;
         g1_rh_ff  <= g1_rh_in;
         g1_req_ff <= dv2_side.req;
      end
   end

   // ---------------- GL and |GR| ----------------
   logic           g2_valid_ff;
   logic [FLW-1:0] g2_gl_ff, g2_gr_ff;
   req_type        g2_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g2_valid_ff <= 1'b0;
      end else if (adv) begin
         g2_valid_ff <= g1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g2_gl_ff  <= FLW'(g1_lh_ff + (FLW+1)'(g1_ll_ff >> FIELD_W));
         g2_gr_ff  <= FLW'(g1_rh_ff + (FLW+1)'(g1_rl_ff >> FIELD_W));
         g2_req_ff <= g1_req_ff;
      end
   end

   // ---------------- momentum partial products ----------------
   logic signed [FIELD_W-1:0] vel_l [3];
   logic signed [FIELD_W-1:0] vel_r [3];
   logic [FIELD_W-1:0]        mag_l [3];
   logic [FIELD_W-1:0]        mag_r [3];
   logic                      h1_valid_ff;
   logic [2*FIELD_W-1:0]      h1_ll_ff [3];
   logic [2*FIELD_W-1:0]      h1_rl_ff [3];
   logic [FLW-1:0]            h1_lh_ff [3];
   logic [FLW-1:0]            h1_rh_ff [3];
   logic [2:0]                h1_negl_ff, h1_negr_ff;
   logic signed [FLW:0]       h1_mass_in, h1_mass_ff;
   logic                      h1_vac_ff;

   always_comb begin
      vel_l[0] = g2_req_ff.vn_left;
      vel_l[1] = g2_req_ff.vt1_left;
      vel_l[2] = g2_req_ff.vt2_left;
      vel_r[0] = g2_req_ff.vn_right;
      vel_r[1] = g2_req_ff.vt1_right;
      vel_r[2] = g2_req_ff.vt2_right;
      for (int k = 0; k < 3; k++) begin
         mag_l[k] = vel_l[k][FIELD_W-1] ? FIELD_W'(-vel_l[k]) : FIELD_W'(vel_l[k]);
         mag_r[k] = vel_r[k][FIELD_W-1] ? FIELD_W'(-vel_r[k]) : FIELD_W'(vel_r[k]);
      end
      h1_mass_in = $signed({1'b0, g2_gl_ff}) - $signed({1'b0, g2_gr_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff <= 1'b0;
      end else if (adv) begin
         h1_valid_ff <= g2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            h1_ll_ff[k]   <= g2_gl_ff[FIELD_W-1:0] * mag_l[k];
            h1_lh_ff[k]   <= g2_gl_ff[FLW-1:FIELD_W] * mag_l[k];
            h1_rl_ff[k]   <= g2_gr_ff[FIELD_W-1:0] * mag_r[k];
            h1_rh_ff[k]   <= g2_gr_ff[FLW-1:FIELD_W] * mag_r[k];
            h1_negl_ff[k] <= vel_l[k][FIELD_W-1];
            h1_negr_ff[k] <= vel_r[k][FIELD_W-1];
         end
         h1_mass_ff <= h1_mass_in;
         h1_vac_ff  <= (g2_req_ff.rho_left == '0) && (g2_req_ff.rho_right == '0);
      end
   end

   // ---------------- full momentum magnitudes ----------------
   logic                h2_valid_ff;
   logic [AW-1:0]       h2_a_ff [3];
   logic [AW-1:0]       h2_b_ff [3];
   logic [2:0]          h2_negl_ff, h2_negr_ff;
   logic signed [FLW:0] h2_mass_ff;
   logic                h2_vac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h2_valid_ff <= 1'b0;
      end else if (adv) begin
         h2_valid_ff <= h1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            h2_a_ff[k] <= AW'(h1_ll_ff[k]) + (AW'(h1_lh_ff[k]) << FIELD_W);
            h2_b_ff[k] <= AW'(h1_rl_ff[k]) + (AW'(h1_rh_ff[k]) << FIELD_W);
         end
         h2_negl_ff <= h1_negl_ff;
         h2_negr_ff <= h1_negr_ff;
         h2_mass_ff <= h1_mass_ff;
         h2_vac_ff  <= h1_vac_ff;
      end
   end

   // ---------------- signed sum vL*GL + vR*GR ----------------
   logic                 h3_valid_ff;
   logic signed [AW+1:0] term_a [3];
   logic signed [AW+1:0] term_b [3];
   logic signed [AW+1:0] h3_s_ff [3];
   logic signed [FLW:0]  h3_mass_ff;
   logic                 h3_vac_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term_a[k] = h2_negl_ff[k] ? -$signed({2'b00, h2_a_ff[k]}) : $signed({2'b00, h2_a_ff[k]});
         term_b[k] = h2_negr_ff[k] ? -$signed({2'b00, h2_b_ff[k]}) : $signed({2'b00, h2_b_ff[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h3_valid_ff <= 1'b0;
      end else if (adv) begin
         h3_valid_ff <= h2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            // GR carries a negative sign, so the right term is subtracted
            h3_s_ff[k] <= term_a[k] - term_b[k];
         end
         h3_mass_ff <= h2_mass_ff;
         h3_vac_ff  <= h2_vac_ff;
      end
   end

   // ---------------- truncate, saturate, output register ----------------
   logic [AW+1:0]     mom_mag [3];
   sat_type           mom_sat [3];
   logic [FLW:0]      mass_mag;
   sat_type           mass_sat;
   logic [FLUX_W-1:0] out_mass_ff, out_mom0_ff, out_mom1_ff, out_mom2_ff;
   logic              out_sat_ff, out_vac_ff, out_sat_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mom_mag[k] = h3_s_ff[k][AW+1] ? (AW+2)'(-h3_s_ff[k]) : (AW+2)'(h3_s_ff[k]);
         mom_sat[k] = sat_flux(h3_s_ff[k][AW+1], SAT_W'(mom_mag[k] >> FRAC_BITS));
      end
      mass_mag   = h3_mass_ff[FLW] ? (FLW+1)'(-h3_mass_ff) : (FLW+1)'(h3_mass_ff);
      mass_sat   = sat_flux(h3_mass_ff[FLW], SAT_W'(mass_mag));
      out_sat_in = !h3_vac_ff &&
                   (mass_sat.sat || mom_sat[0].sat || mom_sat[1].sat || mom_sat[2].sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= h3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_mass_ff <= h3_vac_ff ? '0 : mass_sat.value;
         out_mom0_ff <= h3_vac_ff ? '0 : mom_sat[0].value;
         out_mom1_ff <= h3_vac_ff ? '0 : mom_sat[1].value;
         out_mom2_ff <= h3_vac_ff ? '0 : mom_sat[2].value;
         out_sat_ff  <= out_sat_in;
         out_vac_ff  <= h3_vac_ff;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.mass_flux       = $signed(out_mass_ff);
   assign rsp_chan.normal_mom_flux = $signed(out_mom0_ff);
   assign rsp_chan.trans1_mom_flux = $signed(out_mom1_ff);
   assign rsp_chan.trans2_mom_flux = $signed(out_mom2_ff);
   assign rsp_chan.saturated       = out_sat_ff;
   assign rsp_chan.vacuum          = out_vac_ff;

endmodule
`default_nettype wire

// ===== sv/phf_checker.sv =====
// Port-level assertions for pressureless_hlle_flux and the bind that
// attaches them. Depends on phf_pkg and the top level.
`default_nettype none
module phf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [phf_pkg::FLUX_W-1:0] mass_flux,
   input logic [phf_pkg::FLUX_W-1:0] normal_mom_flux,
   input logic [phf_pkg::FLUX_W-1:0] trans1_mom_flux,
   input logic [phf_pkg::FLUX_W-1:0] trans2_mom_flux,
   input logic                      saturated,
   input logic                      vacuum
);
   import phf_pkg::*;

   // empty output stage never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req ready low with empty output");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_vacuum_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && vacuum) |-> (mass_flux == '0 && normal_mom_flux == '0 &&
         trans1_mom_flux == '0 && trans2_mom_flux == '0 && !saturated))
      else $error("vacuum beat with nonzero flux");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && saturated) |-> (mass_flux == FLUX_MAX || mass_flux == FLUX_MIN ||
         normal_mom_flux == FLUX_MAX || normal_mom_flux == FLUX_MIN ||
         trans1_mom_flux == FLUX_MAX || trans1_mom_flux == FLUX_MIN ||
         trans2_mom_flux == FLUX_MAX || trans2_mom_flux == FLUX_MIN))
      else $error("saturated flag without a clipped flux");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(mass_flux) &&
         $stable(normal_mom_flux) && $stable(saturated)))
      else $error("stalled response beat changed");

endmodule

bind pressureless_hlle_flux phf_checker u_phf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .mass_flux      (rsp_chan.mass_flux),
   .normal_mom_flux(rsp_chan.normal_mom_flux),
   .trans1_mom_flux(rsp_chan.trans1_mom_flux),
   .trans2_mom_flux(rsp_chan.trans2_mom_flux),
   .saturated      (rsp_chan.saturated),
   .vacuum         (rsp_chan.vacuum)
);
`default_nettype wire
